// ----- rtl/core/mmts_pkg.sv -----
package mmts_pkg;

  localparam int DEPTH       = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int MAX_W       = VALUE_WIDTH - 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int SUM_W       = VALUE_WIDTH + $clog2(DEPTH);
  localparam int STEP_W      = $clog2(SUM_W + 1);

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // shift command broadcast to every cell of the stack chain
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/core/mmts_cell.sv -----
module mmts_cell import mmts_pkg::*; (
  input  logic                          clk,
  input  shift_t                        shift,
  input  logic signed [VALUE_WIDTH-1:0] up_val,
  input  logic        [MAX_W-1:0]       up_pmax,
  input  logic signed [VALUE_WIDTH-1:0] dn_val,
  input  logic        [MAX_W-1:0]       dn_pmax,
  output logic signed [VALUE_WIDTH-1:0] val,
  output logic        [MAX_W-1:0]       pmax
);

  // pmax holds the largest entry at or below this cell, floored at zero
  logic signed [VALUE_WIDTH-1:0] val_r;
  logic        [MAX_W-1:0]       pmax_r;

  always_ff @(posedge clk) begin
    if (shift.push) begin
      val_r  <= up_val;
      pmax_r <= up_pmax;
    end else if (shift.pop) begin
      val_r  <= dn_val;
      pmax_r <= dn_pmax;
    end
  end

  assign val  = val_r;
  assign pmax = pmax_r;

endmodule

// ----- rtl/core/mmts_div.sv -----
module mmts_div import mmts_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [SUM_W-1:0]       dividend,
  input  logic        [CNT_W-1:0]       divisor,
  output div_stat_t                     stat,
  output logic signed [VALUE_WIDTH-1:0] quotient
);

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r;
  logic              neg_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    rem_sh;
  logic              fits;
  logic [SUM_W-1:0]  quo_signed;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh   = {rem_r[CNT_W-1:0], quo_r[SUM_W-1]};
    fits     = rem_sh >= {1'b0, dvs_r};
    rem_nxt  = fits ? rem_sh - {1'b0, dvs_r} : rem_sh;
    quo_nxt  = {quo_r[SUM_W-2:0], fits};
    step_nxt = step_r + 1'b1;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r && step_r == STEP_W'(SUM_W - 1)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (busy_r) begin
        step_r <= step_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      quo_r <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // truncation toward zero: divide magnitudes, then restore the sign
  assign quo_signed = neg_r ? SUM_W'(-quo_r) : quo_r;
  assign quotient   = quo_signed[VALUE_WIDTH-1:0];
  assign stat.busy  = busy_r;
  assign stat.done  = done_r;

endmodule

// ----- rtl/core/max_mean_tracking_stack.sv -----
// Channel   Dir  tdata                                  tuser
// in_       in   value[31:0]                            mode (0 push, 1 pop)
// out_      out  top, max, mean, item_count (104 bits)  accepted, empty_res
//
// One item at a time; the mean is formed by the 40-step bit-serial divider.
// The stack is a chain of cells that shift down on push and up on pop; each
// cell carries the running maximum of itself and everything below it.
// in_tready is low from acceptance until the result has been taken.
// rst_n clears the count, the total and the control; cell contents need none.
module max_mean_tracking_stack import mmts_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [VALUE_WIDTH-1:0]    in_tdata,   // [31:0] value
  input  logic                      in_tuser,   // [0] mode
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [31:0] top_value, [62:32] max_value, [94:63] mean_value, [103:95] item_count
  output logic [103:0]              out_tdata,
  output logic [1:0]                out_tuser   // [0] accepted, [1] empty_res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] total_r, total_nxt;
  logic                    ok_r, ok_nxt;
  logic [103:0]            odata_r;
  logic [1:0]              ouser_r;

  logic                    in_acc;
  logic                    push_ok, pop_ok;
  shift_t                  shift;
  logic signed [VALUE_WIDTH-1:0] push_val;
  logic [MAX_W-1:0]        val_floor, old_max, push_pmax;
  logic                    div_start;
  div_stat_t               div_stat;
  logic signed [VALUE_WIDTH-1:0] div_q;

  logic signed [VALUE_WIDTH-1:0] cell_val  [DEPTH];
  logic        [MAX_W-1:0]       cell_pmax [DEPTH];

  logic                    nonempty;
  logic [VALUE_WIDTH-1:0]  top_o, mean_o;
  logic [MAX_W-1:0]        max_o;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign push_ok   = (in_tuser == MODE_PUSH) && (cnt_r != CNT_W'(DEPTH));
  assign pop_ok    = (in_tuser == MODE_POP) && (cnt_r != '0);

  assign shift.push = in_acc && push_ok;
  assign shift.pop  = in_acc && pop_ok;

  // new top cell: value and the maximum over it and the rest of the stack
  assign push_val  = signed'(in_tdata);
  assign val_floor = push_val[VALUE_WIDTH-1] ? '0 : push_val[MAX_W-1:0];
  assign old_max   = (cnt_r != '0) ? cell_pmax[0] : '0;
  assign push_pmax = (val_floor > old_max) ? val_floor : old_max;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] up_v, dn_v;
    logic        [MAX_W-1:0]       up_m, dn_m;
    if (i == 0) begin : g_head
      assign up_v = push_val;
      assign up_m = push_pmax;
    end else begin : g_mid
      assign up_v = cell_val[i-1];
      assign up_m = cell_pmax[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign dn_v = '0;
      assign dn_m = '0;
    end else begin : g_body
      assign dn_v = cell_val[i+1];
      assign dn_m = cell_pmax[i+1];
    end
    mmts_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .up_val  (up_v),
      .up_pmax (up_m),
      .dn_val  (dn_v),
      .dn_pmax (dn_m),
      .val     (cell_val[i]),
      .pmax    (cell_pmax[i])
    );
  end

  assign div_start = (state_r == S_START);

  mmts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_r),
    .divisor  (cnt_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    ok_nxt    = ok_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ok_nxt    = push_ok || pop_ok;
          state_nxt = S_START;
          if (push_ok) begin
            cnt_nxt   = cnt_r + 1'b1;
            total_nxt = total_r + SUM_W'(push_val);
          end else if (pop_ok) begin
            cnt_nxt   = cnt_r - 1'b1;
            total_nxt = total_r - SUM_W'(cell_val[0]);
          end
        end
      end
      S_START: state_nxt = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      total_r <= '0;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      ok_r    <= ok_nxt;
    end
  end

  // hold the result until taken; cells beyond the fill level read as empty
  assign nonempty = (cnt_r != '0);
  assign top_o    = nonempty ? cell_val[0] : '0;
  assign max_o    = nonempty ? cell_pmax[0] : '0;
  assign mean_o   = nonempty ? div_q : '0;

  always_ff @(posedge clk) begin
    if (state_r == S_DIV && div_stat.done) begin
      odata_r <= {cnt_r, mean_o, max_o, top_o};
      ouser_r <= {!nonempty, ok_r};
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

endmodule
